// ===== sv/mtpm_pkg.sv =====
// Shared types, constants and helper functions of the trie prefix-match block.
package mtpm_pkg;

  localparam int KEY_BYTES  = 4;
  localparam int NODE_BITS  = 8;
  localparam int IDX_BITS   = 8;
  localparam int TRIE_AW    = NODE_BITS + IDX_BITS;
  localparam int VALUE_BITS = 16;
  localparam int CNT_BITS   = 9;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_LONG = 2'd3;

  localparam logic [5:0] MAX_LEN     = 6'(KEY_BYTES * 8);
  localparam logic [2:0] KB_MAX      = 3'(KEY_BYTES);
  localparam logic [CNT_BITS-1:0] POOL_FULL = CNT_BITS'((1 << NODE_BITS) - 1);

  typedef struct packed {
    logic [NODE_BITS-1:0]  link;
    logic                  valid;
    logic [VALUE_BITS-1:0] value;
  } trie_word_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]  child_cnt;
    logic [CNT_BITS-1:0]  slot_cnt;
    logic [NODE_BITS-1:0] parent;
    logic [IDX_BITS-1:0]  arrival;
  } node_info_t;

  typedef struct packed {
    logic [1:0]            action;
    logic [31:0]           key;
    logic [5:0]            prefix_length;
    logic [VALUE_BITS-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [VALUE_BITS-1:0] result_value;
  } rsp_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_WALK_RD, S_WALK_WT, S_DECIDE,
    S_SLOT_RD, S_SLOT_WT, S_NSC_RD, S_NSC_WT,
    S_NCC_RD, S_NCC_WT, S_POOL_RD, S_POOL_WT, S_FIN_WR,
    S_DSLOT_RD, S_DSLOT_WT, S_DSC_RD, S_DSC_WT,
    S_PR_CHK, S_PR_LINK_RD, S_PR_LINK_WT, S_PR_NODE_RD, S_PR_NODE_WT,
    S_LK_LVL, S_LK_SLOT_RD, S_LK_SLOT_WT, S_LK_LINK_RD, S_LK_LINK_WT,
    S_LK_FIN_RD, S_LK_FIN_WT, S_DONE
  } state_t;

  // Byte i of the key, first byte in the top bits; past the key reads zero
  function automatic logic [7:0] byte_of(input logic [31:0] key, input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = key[31:24];
      3'd1:    b = key[23:16];
      3'd2:    b = key[15:8];
      3'd3:    b = key[7:0];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  // Slot of a partial-byte prefix of r bits: marker bit over the top r bits
  function automatic logic [7:0] slot_of(input logic [2:0] r, input logic [7:0] b);
    logic [7:0] s;
    case (r)
      3'd0:    s = 8'h01;
      3'd1:    s = {6'b000001, b[7]};
      3'd2:    s = {5'b00001, b[7:6]};
      3'd3:    s = {4'b0001, b[7:5]};
      3'd4:    s = {3'b001, b[7:4]};
      3'd5:    s = {2'b01, b[7:3]};
      3'd6:    s = {1'b1, b[7:2]};
      default: s = {1'b1, b[7:1]};
    endcase
    return s;
  endfunction

endpackage

// ===== sv/mtpm_if.sv =====
// Request and result channel interfaces of the trie prefix-match block.
interface mtpm_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      action;
  logic [31:0]                     key;
  logic [5:0]                      prefix_length;
  logic [mtpm_pkg::VALUE_BITS-1:0] entry_value;
  modport source (output valid, action, key, prefix_length, entry_value, input ready);
  modport sink (input valid, action, key, prefix_length, entry_value, output ready);
endinterface

interface mtpm_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [mtpm_pkg::VALUE_BITS-1:0] result_value;
  modport source (output valid, status, result_value, input ready);
  modport sink (input valid, status, result_value, output ready);
endinterface

// ===== sv/multibit_trie_prefix_match.sv =====
// Top level: 8-bit stride trie longest-prefix match, one request at a time.
// Lookup probes the slots of each level, longest first, then reads the child link, up to four key bytes.
// Insert walks the existing links, then writes the slot or grows a chain of new nodes.
// Delete walks the existing links, then clears the slot and prunes nodes left empty.
// After reset a clearing pass sweeps all 65536 trie RAM entries; no request is taken meanwhile.
// A result waits in an output register while the next request is accepted.
module multibit_trie_prefix_match (
  input  logic             clk,
  input  logic             rst_n,
  mtpm_req_if.sink         in_ch,
  mtpm_rsp_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_wdata
);
  logic [2:0]           key_bytes_r;
  logic                 out_valid_r;
  mtpm_pkg::rsp_t       out_rsp_r;
  mtpm_pkg::req_t       req;
  mtpm_pkg::rsp_t       rsp;
  logic                 rsp_valid;
  logic                 out_free;

  logic                           trie_we, trie_re;
  logic [mtpm_pkg::TRIE_AW-1:0]   trie_addr;
  mtpm_pkg::trie_word_t           trie_wdata, trie_rdata;
  logic                           node_we, node_re;
  logic [mtpm_pkg::NODE_BITS-1:0] node_addr;
  mtpm_pkg::node_info_t           node_wdata, node_rdata;
  logic                           pool_we, pool_re;
  logic [mtpm_pkg::NODE_BITS-1:0] pool_addr, pool_wdata, pool_rdata;

  assign req.action        = in_ch.action;
  assign req.key           = in_ch.key;
  assign req.prefix_length = in_ch.prefix_length;
  assign req.entry_value   = in_ch.entry_value;

  assign out_free            = !out_valid_r || out_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_rsp_r.status;
  assign out_ch.result_value = out_rsp_r.result_value;

  // hold the lookup depth register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bytes_r <= mtpm_pkg::KB_MAX;
    end else if (cfg_we) begin
      key_bytes_r <= cfg_wdata;
    end
  end

  // output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && out_free) begin
      out_rsp_r <= rsp;
    end
  end

  mtpm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .req        (req),
    .key_bytes  (key_bytes_r),
    .rsp_valid  (rsp_valid),
    .rsp        (rsp),
    .out_free   (out_free),
    .trie_we    (trie_we),
    .trie_re    (trie_re),
    .trie_addr  (trie_addr),
    .trie_wdata (trie_wdata),
    .trie_rdata (trie_rdata),
    .node_we    (node_we),
    .node_re    (node_re),
    .node_addr  (node_addr),
    .node_wdata (node_wdata),
    .node_rdata (node_rdata),
    .pool_we    (pool_we),
    .pool_re    (pool_re),
    .pool_addr  (pool_addr),
    .pool_wdata (pool_wdata),
    .pool_rdata (pool_rdata)
  );

  mtpm_ram #(.W($bits(mtpm_pkg::trie_word_t)), .D(1 << mtpm_pkg::TRIE_AW)) u_trie_ram (
    .clk   (clk),
    .we    (trie_we),
    .re    (trie_re),
    .addr  (trie_addr),
    .wdata (trie_wdata),
    .rdata (trie_rdata)
  );

  mtpm_ram #(.W($bits(mtpm_pkg::node_info_t)), .D(1 << mtpm_pkg::NODE_BITS)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .re    (node_re),
    .addr  (node_addr),
    .wdata (node_wdata),
    .rdata (node_rdata)
  );

  mtpm_ram #(.W(mtpm_pkg::NODE_BITS), .D(1 << mtpm_pkg::NODE_BITS)) u_pool_ram (
    .clk   (clk),
    .we    (pool_we),
    .re    (pool_re),
    .addr  (pool_addr),
    .wdata (pool_wdata),
    .rdata (pool_rdata)
  );
endmodule

// ===== sv/mtpm_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module mtpm_ram #(
  parameter int W = 8,
  parameter int D = 256,
  localparam int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [W-1:0]  wdata,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  // write or read one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

// ===== sv/mtpm_seq.sv =====
// Sequencer: walks the trie memory for insert, delete with pruning, and lookup.
module mtpm_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mtpm_pkg::req_t                 req,
  input  logic [2:0]                     key_bytes,
  output logic                           rsp_valid,
  output mtpm_pkg::rsp_t                 rsp,
  input  logic                           out_free,
  output logic                           trie_we,
  output logic                           trie_re,
  output logic [mtpm_pkg::TRIE_AW-1:0]   trie_addr,
  output mtpm_pkg::trie_word_t           trie_wdata,
  input  mtpm_pkg::trie_word_t           trie_rdata,
  output logic                           node_we,
  output logic                           node_re,
  output logic [mtpm_pkg::NODE_BITS-1:0] node_addr,
  output mtpm_pkg::node_info_t           node_wdata,
  input  mtpm_pkg::node_info_t           node_rdata,
  output logic                           pool_we,
  output logic                           pool_re,
  output logic [mtpm_pkg::NODE_BITS-1:0] pool_addr,
  output logic [mtpm_pkg::NODE_BITS-1:0] pool_wdata,
  input  logic [mtpm_pkg::NODE_BITS-1:0] pool_rdata
);
  mtpm_pkg::state_t state_r, state_nxt;
  logic [mtpm_pkg::TRIE_AW-1:0]    clr_r, clr_nxt;
  logic [mtpm_pkg::CNT_BITS-1:0]   free_r, free_nxt;
  logic [1:0]                      op_r, op_nxt;
  logic [31:0]                     key_r, key_nxt;
  logic [5:0]                      len_r, len_nxt;
  logic [mtpm_pkg::VALUE_BITS-1:0] val_r, val_nxt;
  logic [mtpm_pkg::NODE_BITS-1:0]  node_r, node_nxt;
  logic [2:0]                      idx_r, idx_nxt;
  logic [2:0]                      kb_r, kb_nxt;
  logic [2:0]                      rr_r, rr_nxt;
  mtpm_pkg::trie_word_t            word_r, word_nxt;
  mtpm_pkg::node_info_t            info_r, info_nxt;
  logic                            found_r, found_nxt;
  logic [mtpm_pkg::VALUE_BITS-1:0] hit_r, hit_nxt;
  logic [1:0]                      status_r, status_nxt;
  logic [mtpm_pkg::VALUE_BITS-1:0] res_r, res_nxt;

  logic [2:0] whole;
  logic [2:0] need;
  logic [7:0] cur_byte;
  logic [7:0] slot_idx;

  assign whole    = len_r[5:3];
  assign need     = whole - idx_r;
  assign cur_byte = mtpm_pkg::byte_of(key_r, idx_r);
  assign slot_idx = mtpm_pkg::slot_of(len_r[2:0], mtpm_pkg::byte_of(key_r, whole));

  assign in_ready         = (state_r == mtpm_pkg::S_IDLE);
  assign rsp_valid        = (state_r == mtpm_pkg::S_DONE);
  assign rsp.status       = status_r;
  assign rsp.result_value = res_r;

  // hold control state in reset, advance otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mtpm_pkg::S_CLEAR;
      clr_r   <= '0;
      free_r  <= mtpm_pkg::POOL_FULL;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      free_r  <= free_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    len_r    <= len_nxt;
    val_r    <= val_nxt;
    node_r   <= node_nxt;
    idx_r    <= idx_nxt;
    kb_r     <= kb_nxt;
    rr_r     <= rr_nxt;
    word_r   <= word_nxt;
    info_r   <= info_nxt;
    found_r  <= found_nxt;
    hit_r    <= hit_nxt;
    status_r <= status_nxt;
    res_r    <= res_nxt;
  end

  // next state and memory accesses
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    free_nxt   = free_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    len_nxt    = len_r;
    val_nxt    = val_r;
    node_nxt   = node_r;
    idx_nxt    = idx_r;
    kb_nxt     = kb_r;
    rr_nxt     = rr_r;
    word_nxt   = word_r;
    info_nxt   = info_r;
    found_nxt  = found_r;
    hit_nxt    = hit_r;
    status_nxt = status_r;
    res_nxt    = res_r;
    trie_we    = 1'b0;
    trie_re    = 1'b0;
    trie_addr  = {node_r, cur_byte};
    trie_wdata = '0;
    node_we    = 1'b0;
    node_re    = 1'b0;
    node_addr  = node_r;
    node_wdata = '0;
    pool_we    = 1'b0;
    pool_re    = 1'b0;
    pool_addr  = free_r[mtpm_pkg::NODE_BITS-1:0];
    pool_wdata = '0;
    unique case (state_r)
      // sweep every memory after reset; the pool gets nodes 255 down to 1
      mtpm_pkg::S_CLEAR: begin
        trie_we   = 1'b1;
        trie_addr = clr_r;
        if (clr_r[mtpm_pkg::TRIE_AW-1:mtpm_pkg::NODE_BITS] == '0) begin
          node_we    = 1'b1;
          node_addr  = clr_r[mtpm_pkg::NODE_BITS-1:0];
          pool_we    = 1'b1;
          pool_addr  = clr_r[mtpm_pkg::NODE_BITS-1:0];
          pool_wdata = 8'hFF - clr_r[mtpm_pkg::NODE_BITS-1:0];
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = mtpm_pkg::S_IDLE;
        end
      end
      mtpm_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt    = req.action;
          key_nxt   = req.key;
          len_nxt   = req.prefix_length;
          val_nxt   = req.entry_value;
          node_nxt  = '0;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          hit_nxt   = '0;
          res_nxt   = '0;
          kb_nxt    = (key_bytes > mtpm_pkg::KB_MAX) ? mtpm_pkg::KB_MAX : key_bytes;
          unique case (req.action) inside
            mtpm_pkg::ACT_INSERT, mtpm_pkg::ACT_DELETE: begin
              if (req.prefix_length > mtpm_pkg::MAX_LEN) begin
                status_nxt = mtpm_pkg::ST_LONG;
                state_nxt  = mtpm_pkg::S_DONE;
              end else begin
                state_nxt = mtpm_pkg::S_WALK_RD;
              end
            end
            mtpm_pkg::ACT_LOOKUP: state_nxt = mtpm_pkg::S_LK_LVL;
            default: begin
              status_nxt = mtpm_pkg::ST_MISS;
              state_nxt  = mtpm_pkg::S_DONE;
            end
          endcase
        end
      end
      // follow existing links over the whole bytes of the prefix
      mtpm_pkg::S_WALK_RD: begin
        if (idx_r < whole) begin
          trie_re   = 1'b1;
          state_nxt = mtpm_pkg::S_WALK_WT;
        end else begin
          state_nxt = mtpm_pkg::S_DECIDE;
        end
      end
      mtpm_pkg::S_WALK_WT: begin
        word_nxt = trie_rdata;
        if (trie_rdata.link != '0) begin
          node_nxt  = trie_rdata.link;
          idx_nxt   = idx_r + 3'd1;
          state_nxt = mtpm_pkg::S_WALK_RD;
        end else begin
          state_nxt = mtpm_pkg::S_DECIDE;
        end
      end
      mtpm_pkg::S_DECIDE: begin
        if (op_r == mtpm_pkg::ACT_INSERT) begin
          if ({6'd0, need} > free_r) begin
            status_nxt = mtpm_pkg::ST_FULL;
            state_nxt  = mtpm_pkg::S_DONE;
          end else if (need == 3'd0) begin
            state_nxt = mtpm_pkg::S_SLOT_RD;
          end else begin
            state_nxt = mtpm_pkg::S_NCC_RD;
          end
        end else if (idx_r != whole) begin
          status_nxt = mtpm_pkg::ST_MISS;
          state_nxt  = mtpm_pkg::S_DONE;
        end else begin
          state_nxt = mtpm_pkg::S_DSLOT_RD;
        end
      end
      // insert into a slot of an existing node
      mtpm_pkg::S_SLOT_RD: begin
        trie_re   = 1'b1;
        trie_addr = {node_r, slot_idx};
        state_nxt = mtpm_pkg::S_SLOT_WT;
      end
      mtpm_pkg::S_SLOT_WT: begin
        trie_we          = 1'b1;
        trie_addr        = {node_r, slot_idx};
        trie_wdata.link  = trie_rdata.link;
        trie_wdata.valid = 1'b1;
        trie_wdata.value = val_r;
        status_nxt       = mtpm_pkg::ST_OK;
        state_nxt        = trie_rdata.valid ? mtpm_pkg::S_DONE : mtpm_pkg::S_NSC_RD;
      end
      mtpm_pkg::S_NSC_RD: begin
        node_re   = 1'b1;
        state_nxt = mtpm_pkg::S_NSC_WT;
      end
      mtpm_pkg::S_NSC_WT: begin
        node_we             = 1'b1;
        node_wdata          = node_rdata;
        node_wdata.slot_cnt = node_rdata.slot_cnt + 1'b1;
        state_nxt           = mtpm_pkg::S_DONE;
      end
      // grow a chain of fresh nodes below the walk's end
      mtpm_pkg::S_NCC_RD: begin
        node_re   = 1'b1;
        state_nxt = mtpm_pkg::S_NCC_WT;
      end
      mtpm_pkg::S_NCC_WT: begin
        node_we              = 1'b1;
        node_wdata           = node_rdata;
        node_wdata.child_cnt = node_rdata.child_cnt + 1'b1;
        state_nxt            = mtpm_pkg::S_POOL_RD;
      end
      mtpm_pkg::S_POOL_RD: begin
        pool_re   = 1'b1;
        pool_addr = free_r[mtpm_pkg::NODE_BITS-1:0] - 1'b1;
        free_nxt  = free_r - 1'b1;
        state_nxt = mtpm_pkg::S_POOL_WT;
      end
      mtpm_pkg::S_POOL_WT: begin
        node_we              = 1'b1;
        node_addr            = pool_rdata;
        node_wdata.child_cnt = (need != 3'd1) ? 9'd1 : 9'd0;
        node_wdata.slot_cnt  = (need == 3'd1) ? 9'd1 : 9'd0;
        node_wdata.parent    = node_r;
        node_wdata.arrival   = cur_byte;
        trie_we              = 1'b1;
        trie_wdata.link      = pool_rdata;
        trie_wdata.valid     = word_r.valid;
        trie_wdata.value     = word_r.value;
        node_nxt             = pool_rdata;
        word_nxt             = '0;
        idx_nxt              = idx_r + 3'd1;
        state_nxt            = (need == 3'd1) ? mtpm_pkg::S_FIN_WR : mtpm_pkg::S_POOL_RD;
      end
      mtpm_pkg::S_FIN_WR: begin
        trie_we          = 1'b1;
        trie_addr        = {node_r, slot_idx};
        trie_wdata.valid = 1'b1;
        trie_wdata.value = val_r;
        status_nxt       = mtpm_pkg::ST_OK;
        state_nxt        = mtpm_pkg::S_DONE;
      end
      // delete: clear the slot and drop its count
      mtpm_pkg::S_DSLOT_RD: begin
        trie_re   = 1'b1;
        trie_addr = {node_r, slot_idx};
        state_nxt = mtpm_pkg::S_DSLOT_WT;
      end
      mtpm_pkg::S_DSLOT_WT: begin
        if (!trie_rdata.valid) begin
          status_nxt = mtpm_pkg::ST_MISS;
          state_nxt  = mtpm_pkg::S_DONE;
        end else begin
          trie_we         = 1'b1;
          trie_addr       = {node_r, slot_idx};
          trie_wdata.link = trie_rdata.link;
          res_nxt         = trie_rdata.value;
          status_nxt      = mtpm_pkg::ST_OK;
          state_nxt       = mtpm_pkg::S_DSC_RD;
        end
      end
      mtpm_pkg::S_DSC_RD: begin
        node_re   = 1'b1;
        state_nxt = mtpm_pkg::S_DSC_WT;
      end
      mtpm_pkg::S_DSC_WT: begin
        node_we             = 1'b1;
        node_wdata          = node_rdata;
        node_wdata.slot_cnt = node_rdata.slot_cnt - 1'b1;
        info_nxt            = node_wdata;
        state_nxt           = mtpm_pkg::S_PR_CHK;
      end
      // prune empty nodes back up toward the root
      mtpm_pkg::S_PR_CHK: begin
        if (node_r != '0 && info_r.slot_cnt == '0 && info_r.child_cnt == '0) begin
          if (!free_r[mtpm_pkg::CNT_BITS-1]) begin
            pool_we    = 1'b1;
            pool_wdata = node_r;
            free_nxt   = free_r + 1'b1;
          end
          state_nxt = mtpm_pkg::S_PR_LINK_RD;
        end else begin
          state_nxt = mtpm_pkg::S_DONE;
        end
      end
      mtpm_pkg::S_PR_LINK_RD: begin
        trie_re   = 1'b1;
        trie_addr = {info_r.parent, info_r.arrival};
        state_nxt = mtpm_pkg::S_PR_LINK_WT;
      end
      mtpm_pkg::S_PR_LINK_WT: begin
        trie_we          = 1'b1;
        trie_addr        = {info_r.parent, info_r.arrival};
        trie_wdata.valid = trie_rdata.valid;
        trie_wdata.value = trie_rdata.value;
        node_nxt         = info_r.parent;
        state_nxt        = mtpm_pkg::S_PR_NODE_RD;
      end
      mtpm_pkg::S_PR_NODE_RD: begin
        node_re   = 1'b1;
        state_nxt = mtpm_pkg::S_PR_NODE_WT;
      end
      mtpm_pkg::S_PR_NODE_WT: begin
        node_we              = 1'b1;
        node_wdata           = node_rdata;
        node_wdata.child_cnt = node_rdata.child_cnt - 1'b1;
        info_nxt             = node_wdata;
        state_nxt            = mtpm_pkg::S_PR_CHK;
      end
      // lookup: per level, longest slot first, then the child link
      mtpm_pkg::S_LK_LVL: begin
        rr_nxt    = 3'd7;
        state_nxt = (idx_r < kb_r) ? mtpm_pkg::S_LK_SLOT_RD : mtpm_pkg::S_LK_FIN_RD;
      end
      mtpm_pkg::S_LK_SLOT_RD: begin
        trie_re   = 1'b1;
        trie_addr = {node_r, mtpm_pkg::slot_of(rr_r, cur_byte)};
        state_nxt = mtpm_pkg::S_LK_SLOT_WT;
      end
      mtpm_pkg::S_LK_SLOT_WT: begin
        if (trie_rdata.valid) begin
          hit_nxt   = trie_rdata.value;
          found_nxt = 1'b1;
          state_nxt = mtpm_pkg::S_LK_LINK_RD;
        end else if (rr_r == 3'd0) begin
          state_nxt = mtpm_pkg::S_LK_LINK_RD;
        end else begin
          rr_nxt    = rr_r - 3'd1;
          state_nxt = mtpm_pkg::S_LK_SLOT_RD;
        end
      end
      mtpm_pkg::S_LK_LINK_RD: begin
        trie_re   = 1'b1;
        state_nxt = mtpm_pkg::S_LK_LINK_WT;
      end
      mtpm_pkg::S_LK_LINK_WT: begin
        if (trie_rdata.link == '0) begin
          status_nxt = found_r ? mtpm_pkg::ST_OK : mtpm_pkg::ST_MISS;
          res_nxt    = found_r ? hit_r : '0;
          state_nxt  = mtpm_pkg::S_DONE;
        end else begin
          node_nxt  = trie_rdata.link;
          idx_nxt   = idx_r + 3'd1;
          state_nxt = mtpm_pkg::S_LK_LVL;
        end
      end
      mtpm_pkg::S_LK_FIN_RD: begin
        trie_re   = 1'b1;
        trie_addr = {node_r, 8'h01};
        state_nxt = mtpm_pkg::S_LK_FIN_WT;
      end
      mtpm_pkg::S_LK_FIN_WT: begin
        if (trie_rdata.valid) begin
          status_nxt = mtpm_pkg::ST_OK;
          res_nxt    = trie_rdata.value;
        end else begin
          status_nxt = found_r ? mtpm_pkg::ST_OK : mtpm_pkg::ST_MISS;
          res_nxt    = found_r ? hit_r : '0;
        end
        state_nxt = mtpm_pkg::S_DONE;
      end
      // hand the result over once the output register can take it
      mtpm_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = mtpm_pkg::S_IDLE;
        end
      end
      default: state_nxt = mtpm_pkg::S_IDLE;
    endcase
  end

  // no request is taken during the clearing sweep
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mtpm_pkg::S_CLEAR |-> !in_ready)
    else $error("request taken during clearing sweep");

  // the free count never exceeds the pool size
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= mtpm_pkg::POOL_FULL)
    else $error("free count out of range");

  // an accepted request closes the input until its result is out
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // lookups never modify the trie
  a_lookup_ro: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtpm_pkg::S_LK_SLOT_WT || state_r == mtpm_pkg::S_LK_LINK_WT ||
     state_r == mtpm_pkg::S_LK_FIN_WT) |-> !trie_we && !node_we && !pool_we)
    else $error("lookup wrote memory");
endmodule

// ===== tb/mtpm_checker.sv =====
// Checker for the trie prefix-match block: predicts every result and compares it.
module mtpm_checker
  import mtpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mtpm_req_if        req_mon,
  mtpm_rsp_if        rsp_mon,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the trie
  logic [7:0]  sh_link [65536];
  logic [15:0] sh_value [65536];
  bit          sh_valid [65536];
  int          sh_children [256];
  int          sh_slots [256];
  int          sh_parent [256];
  int          sh_arrival [256];
  int          sh_pool [256];
  int          sh_free;
  logic [2:0]  sh_key_bytes;

  rsp_t expected_rsp_q [$];

  function automatic int key_byte(logic [31:0] k, int i);
    if (i >= KEY_BYTES) return 0;
    return (k >> (8 * (KEY_BYTES - 1 - i))) & 8'hFF;
  endfunction

  function automatic int slot_index(int r, int b);
    return ((1 << r) | (b >> (8 - r))) & 8'hFF;
  endfunction

  // Apply one request to the shadow trie and return the result it should give
  function automatic rsp_t predict_match(req_t rq);
    rsp_t rs;
    int node, i, whole, r, s, b, n, p, kb, probe;
    bit found, walked;
    rs.status = ST_MISS;
    rs.result_value = '0;
    node = 0;
    if (rq.action == ACT_INSERT || rq.action == ACT_DELETE) begin
      whole = rq.prefix_length >> 3;
      r = rq.prefix_length & 7;
      if (rq.prefix_length > MAX_LEN) begin
        rs.status = ST_LONG;
      end else begin
        i = 0;
        while (i < whole && sh_link[node * 256 + key_byte(rq.key, i)] != 0) begin
          node = sh_link[node * 256 + key_byte(rq.key, i)];
          i++;
        end
        if (rq.action == ACT_INSERT) begin
          if (whole - i > sh_free) begin
            rs.status = ST_FULL;
          end else begin
            // take fresh nodes for the missing bytes
            while (i < whole) begin
              b = key_byte(rq.key, i);
              sh_free--;
              n = sh_pool[sh_free];
              sh_children[n] = 0;
              sh_slots[n] = 0;
              sh_parent[n] = node;
              sh_arrival[n] = b;
              sh_link[node * 256 + b] = n[7:0];
              sh_children[node]++;
              node = n;
              i++;
            end
            s = node * 256 + slot_index(r, key_byte(rq.key, whole));
            if (!sh_valid[s]) begin
              sh_valid[s] = 1;
              sh_slots[node]++;
            end
            sh_value[s] = rq.entry_value;
            rs.status = ST_OK;
          end
        end else if (i == whole) begin
          s = node * 256 + slot_index(r, key_byte(rq.key, whole));
          if (sh_valid[s]) begin
            rs.result_value = sh_value[s];
            sh_valid[s] = 0;
            sh_value[s] = '0;
            sh_slots[node]--;
            // prune empty nodes back toward the root
            while (node != 0 && sh_slots[node] == 0 && sh_children[node] == 0) begin
              p = sh_parent[node];
              sh_link[p * 256 + sh_arrival[node]] = '0;
              sh_children[p]--;
              if (sh_free < 256) begin
                sh_pool[sh_free] = node;
                sh_free++;
              end
              node = p;
            end
            rs.status = ST_OK;
          end
        end
      end
    end else if (rq.action == ACT_LOOKUP) begin
      kb = (sh_key_bytes > KB_MAX) ? KEY_BYTES : sh_key_bytes;
      found = 0;
      walked = 1;
      for (i = 0; i < kb; i++) begin
        b = key_byte(rq.key, i);
        for (probe = 7; probe >= 0; probe--) begin
          s = node * 256 + slot_index(probe, b);
          if (sh_valid[s]) begin
            rs.result_value = sh_value[s];
            found = 1;
            break;
          end
        end
        if (sh_link[node * 256 + b] == 0) begin
          walked = 0;
          break;
        end
        node = sh_link[node * 256 + b];
      end
      if (walked && sh_valid[node * 256 + 1]) begin
        rs.result_value = sh_value[node * 256 + 1];
        found = 1;
      end
      if (found) rs.status = ST_OK;
      else rs.result_value = '0;
    end
    return rs;
  endfunction

  assign pending = expected_rsp_q.size();

  // Track configuration, predict on each request, compare on each result
  always @(posedge clk) begin
    req_t rq;
    rsp_t want;
    if (!rst_n) begin
      for (int k = 0; k < 65536; k++) begin
        sh_link[k] = '0;
        sh_valid[k] = 0;
        sh_value[k] = '0;
      end
      for (int k = 0; k < 256; k++) begin
        sh_children[k] = 0;
        sh_slots[k] = 0;
        sh_parent[k] = 0;
        sh_arrival[k] = 0;
        sh_pool[k] = 0;
      end
      for (int k = 0; k < 255; k++) sh_pool[k] = 255 - k;
      sh_free = 255;
      sh_key_bytes = 3'd4;
      expected_rsp_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) sh_key_bytes = cfg_wdata;
      if (req_mon.valid && req_mon.ready) begin
        rq.action = req_mon.action;
        rq.key = req_mon.key;
        rq.prefix_length = req_mon.prefix_length;
        rq.entry_value = req_mon.entry_value;
        expected_rsp_q.push_back(predict_match(rq));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result with no request outstanding: status %0d value %h",
                 rsp_mon.status, rsp_mon.result_value);
          fail_count++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_mon.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_mon.status);
            fail_count++;
          end
          if (rsp_mon.result_value !== want.result_value) begin
            $error("result_value: expected %h, actual %h",
                   want.result_value, rsp_mon.result_value);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the trie prefix-match testbench: clock, reset, requests, verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mtpm_pkg::*;

  localparam int STALL_LIMIT = 300000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_wdata;
  int         fail_count;
  int         pending;
  int         tx_idle_pct;
  int         rx_idle_pct;
  bit         hold_off_req;
  int         hold_left;
  int         quiet_cycles = 0;
  logic [31:0] base_keys [6];
  logic [31:0] fill_keys [$];

  mtpm_req_if req_ch ();
  mtpm_rsp_if rsp_ch ();

  multibit_trie_prefix_match u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch.sink),
    .out_ch    (rsp_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  mtpm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (req_ch),
    .rsp_mon    (rsp_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Drive result ready: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else begin
      if (hold_off_req && hold_left == 0) hold_left <= 1500;
      if (hold_left > 1) begin
        rsp_ch.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else begin
        if (hold_left == 1) hold_left <= -1;
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one request, idling first at the sender's rate
  task automatic send_request(logic [1:0] act, logic [31:0] k, logic [5:0] len,
                              logic [15:0] val);
    if ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    req_ch.valid         <= 1'b1;
    req_ch.action        <= act;
    req_ch.key           <= k;
    req_ch.prefix_length <= len;
    req_ch.entry_value   <= val;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drain outstanding results, then write key_bytes
  task automatic set_key_bytes(logic [2:0] kb);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= kb;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random request mostly near a few base prefixes so that matches happen
  task automatic send_random;
    logic [31:0] k;
    logic [1:0]  act;
    logic [5:0]  len;
    int pick;
    k = base_keys[$urandom_range(5)];
    case ($urandom_range(3))
      0: k = k;
      1: k = k ^ ($urandom & 32'h0000_00FF);
      2: k = k ^ ($urandom & 32'h0000_FFFF);
      default: k = $urandom;
    endcase
    pick = $urandom_range(99);
    if (pick < 35) act = ACT_INSERT;
    else if (pick < 55) act = ACT_DELETE;
    else if (pick < 95) act = ACT_LOOKUP;
    else act = 2'd3;
    len = ($urandom_range(99) < 6) ? 6'($urandom_range(63, 33)) : 6'($urandom_range(32));
    send_request(act, k, len, 16'($urandom));
  endtask

  initial begin
    logic [2:0] kb_plan [6];
    logic [31:0] k;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_LOOKUP;
    req_ch.key = '0;
    req_ch.prefix_length = '0;
    req_ch.entry_value = '0;
    tx_idle_pct = 15;
    rx_idle_pct = 81;
    hold_off_req = 0;
    kb_plan = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4};
    foreach (base_keys[j]) base_keys[j] = $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every action and the special cases
    set_key_bytes(3'd4);
    send_request(ACT_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000);
    send_request(ACT_INSERT, 32'h0000_0000, 6'd0, 16'h0000);
    send_request(ACT_LOOKUP, 32'hDEAD_BEEF, 6'd0, 16'h0000);
    send_request(ACT_INSERT, 32'hFFFF_FFFF, 6'd32, 16'hFFFF);
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
    send_request(ACT_INSERT, 32'h0A00_0000, 6'd8, 16'h0001);
    send_request(ACT_INSERT, 32'h0A00_0000, 6'd8, 16'h0002);
    send_request(ACT_INSERT, 32'h0A80_0000, 6'd9, 16'h0003);
    send_request(ACT_LOOKUP, 32'h0A0B_0C0D, 6'd0, 16'h0000);
    send_request(ACT_LOOKUP, 32'h0A8B_0C0D, 6'd0, 16'h0000);
    send_request(ACT_INSERT, 32'h1234_5678, 6'd33, 16'h5555);
    send_request(ACT_DELETE, 32'h1234_5678, 6'd63, 16'h0000);
    send_request(ACT_DELETE, 32'h1234_5678, 6'd24, 16'h0000);
    send_request(2'd3, 32'hFFFF_FFFF, 6'd32, 16'hFFFF);
    send_request(ACT_DELETE, 32'h0A80_0000, 6'd9, 16'h0000);
    send_request(ACT_DELETE, 32'hFFFF_FFFF, 6'd32, 16'h0000);
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0, 16'h0000);
    send_request(ACT_INSERT, 32'h8000_0000, 6'd1, 16'h1234);
    send_request(ACT_LOOKUP, 32'h8000_0001, 6'd0, 16'h0000);
    send_request(ACT_DELETE, 32'h8000_0000, 6'd1, 16'h0000);
    send_request(ACT_DELETE, 32'h0000_0000, 6'd0, 16'h0000);

    // Exhaust the node pool with full-length prefixes, then remove them
    tx_idle_pct = 15;
    rx_idle_pct = 81;
    for (int n = 0; n < 80; n++) begin
      k = $urandom;
      fill_keys.push_back(k);
      send_request(ACT_INSERT, k, 6'd32, 16'($urandom));
    end
    send_request(ACT_LOOKUP, fill_keys[3], 6'd0, 16'h0000);
    foreach (fill_keys[j]) send_request(ACT_DELETE, fill_keys[j], 6'd32, 16'h0000);

    // Random phases over several key_bytes settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      set_key_bytes(kb_plan[ph]);
      case (ph / 2)
        0: begin tx_idle_pct = 15; rx_idle_pct = 81; end
        1: begin tx_idle_pct = 81; rx_idle_pct = 15; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int n = 0; n < 110; n++) begin
        if (ph == 4 && n == 10) hold_off_req = 1;
        send_random();
      end
    end

    // Wait for the last results and let the block settle
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
